### rtl/wld_pkg.sv
// Shared constants, codes and types of the work line dispatcher.
package wld_pkg;

  localparam int LINE_MAX   = 1024;
  localparam int LINE_BITS  = $clog2(LINE_MAX);
  localparam int CNT_BITS   = $clog2(LINE_MAX + 1);
  localparam int STAMP_BITS = 32;

  localparam int OP_BITS     = 2;
  localparam int INDEX_BITS  = 12;
  localparam int SCENE_BITS  = 31;
  localparam int PIXEL_BITS  = 16;
  localparam int TIME_BITS   = 32;
  localparam int STATUS_BITS = 3;
  localparam int PCT_BITS    = 7;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 31;

  // Percent dividend is received_count * 100.
  localparam int PCT_SCALE     = 100;
  localparam int DIVIDEND_BITS = $clog2(LINE_MAX * PCT_SCALE + 1);
  localparam int DIV_CNT_BITS  = $clog2(DIVIDEND_BITS);

  localparam logic [OP_BITS-1:0] OP_REQUEST = 2'd0;
  localparam logic [OP_BITS-1:0] OP_REPORT  = 2'd1;
  localparam logic [OP_BITS-1:0] OP_RESTART = 2'd2;

  localparam logic [STATUS_BITS-1:0] ST_GRANTED  = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_NONE     = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_STORED   = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_DUP      = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_COMPLETE = 3'd4;
  localparam logic [STATUS_BITS-1:0] ST_REJECT   = 3'd5;

  localparam logic [CFG_INDEX_BITS-1:0] REG_LINE_TOTAL = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PIXELS     = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SCENE      = 2'd2;

  typedef struct packed {
    logic                  received;
    logic [STAMP_BITS-1:0] stamp;
  } line_entry_t;

  typedef struct packed {
    logic                     start;
    logic [DIVIDEND_BITS-1:0] dividend;
    logic [CNT_BITS-1:0]      divisor;
  } div_req_t;

  typedef struct packed {
    logic                     done;
    logic [DIVIDEND_BITS-1:0] quotient;
  } div_rsp_t;

endpackage

### rtl/wld_ifs.sv
// Valid/ready channel interfaces for the dispatcher's input and result beats.
interface wld_item_if import wld_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [OP_BITS-1:0]    opcode;
  logic [INDEX_BITS-1:0] line_number;
  logic [SCENE_BITS-1:0] reported_scene;
  logic [PIXEL_BITS-1:0] reported_pixels;
  logic [TIME_BITS-1:0]  now_time;

  modport source (output valid, opcode, line_number, reported_scene, reported_pixels,
                  now_time, input ready);
  modport sink (input valid, opcode, line_number, reported_scene, reported_pixels,
                now_time, output ready);
endinterface

interface wld_result_if import wld_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [STATUS_BITS-1:0] status;
  logic [LINE_BITS-1:0]   granted_line;
  logic [PCT_BITS-1:0]    percent_done;

  modport source (output valid, status, granted_line, percent_done, input ready);
  modport sink (input valid, status, granted_line, percent_done, output ready);
endinterface

### rtl/wld_div.sv
// Restoring divider, one quotient bit per cycle, for the percent figure.
module wld_div import wld_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                     busy;
  logic                     done;
  logic [DIV_CNT_BITS-1:0]  step;
  logic [CNT_BITS-1:0]      divisor;
  logic [CNT_BITS-1:0]      rem;
  logic [DIVIDEND_BITS-1:0] quo;
  logic [CNT_BITS:0]        rem_sh;
  logic                     take;

  assign rem_sh = {rem, quo[DIVIDEND_BITS-1]};
  assign take   = rem_sh >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == DIV_CNT_BITS'(DIVIDEND_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The dividend shifts out of the quotient register as quotient bits shift in.
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo     <= req.dividend;
      rem     <= '0;
      divisor <= req.divisor;
    end else if (busy) begin
      if (take) begin
        rem <= CNT_BITS'(rem_sh - {1'b0, divisor});
      end else begin
        rem <= rem_sh[CNT_BITS-1:0];
      end
      quo <= {quo[DIVIDEND_BITS-2:0], take};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

### rtl/work_line_dispatcher.sv
// Top level of the work line dispatcher: line table, sequencer, divider and result register.
//
// Workers send beats on the items channel: a request for a line, a report of a
// finished line, or a restart. Each accepted beat yields exactly one beat on the
// results channel with a status, the granted line and the percent done.
// Configuration (line total, pixels per line, scene tag) is written through cfg_we/
// cfg_index/cfg_data; the user must do so only while no item is in flight (not enforced).
//
// One item is worked at a time. A re-grant request and a stored report walk the line
// table one entry per cycle through the single read port. Every item ends with the
// percent figure: a start state, 17 bit-serial divider steps, a flag on the quotient
// and the load of the result.
//
// After reset, and on every restart, a clearing pass writes all 1024 table
// entries, one a cycle; no item is accepted during the reset pass and the
// restart answers when its pass has ended. The result register frees the
// sequencer: a new item is taken while a result waits, but that item cannot
// deliver until the receiver has taken the waiting beat.
module work_line_dispatcher import wld_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  wld_item_if.sink                  items,
  wld_result_if.source              results
);

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_GRANT_RD = 4'd2;
  localparam logic [3:0] S_REP_RD   = 4'd3;
  localparam logic [3:0] S_SCAN     = 4'd4;
  localparam logic [3:0] S_DIV_GO   = 4'd5;
  localparam logic [3:0] S_DIV_WAIT = 4'd6;
  localparam logic [3:0] S_FIN      = 4'd7;

  // Configuration registers.
  logic [CNT_BITS-1:0]   line_total;
  logic [PIXEL_BITS-1:0] pixels_per_line;
  logic [SCENE_BITS-1:0] scene_tag;
  logic [CNT_BITS-1:0]   lines_n;

  // Sequencer and line state.
  logic [3:0]             st;
  logic                   clr_answer;
  logic [CNT_BITS-1:0]    given_count;
  logic [CNT_BITS-1:0]    recv_count;
  logic                   image_done;
  logic                   scan_report;
  logic [CNT_BITS-1:0]    scan_ptr;
  logic                   rd_v;
  logic [LINE_BITS-1:0]   rd_idx;
  logic                   found;
  logic [LINE_BITS-1:0]   best;
  logic [STAMP_BITS-1:0]  best_stamp;
  logic [LINE_BITS-1:0]   cur_line;
  logic [STAMP_BITS-1:0]  now_r;
  logic [STATUS_BITS-1:0] res_status;
  logic [LINE_BITS-1:0]   res_line;

  // Result register.
  logic                   out_valid;
  logic [STATUS_BITS-1:0] out_status;
  logic [LINE_BITS-1:0]   out_line;
  logic [PCT_BITS-1:0]    out_pct;

  // Line table: one read port and one write port.
  line_entry_t            mem [LINE_MAX];
  line_entry_t            rdata;
  logic [LINE_BITS-1:0]   rd_addr;
  logic                   mem_we;
  logic [LINE_BITS-1:0]   mem_waddr;
  line_entry_t            mem_wdata;

  div_req_t               div_req;
  div_rsp_t               div_rsp;

  logic                   accept;
  logic                   report_ok;
  logic                   scan_issue;
  logic                   out_free;
  logic [PCT_BITS-1:0]    pct;

  always_comb begin
    if (line_total == '0) begin
      lines_n = CNT_BITS'(1);
    end else if (line_total > CNT_BITS'(LINE_MAX)) begin
      lines_n = CNT_BITS'(LINE_MAX);
    end else begin
      lines_n = line_total;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_total      <= CNT_BITS'(1);
      pixels_per_line <= PIXEL_BITS'(1);
      scene_tag       <= SCENE_BITS'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LINE_TOTAL: line_total      <= cfg_data[CNT_BITS-1:0];
        REG_PIXELS:     pixels_per_line <= cfg_data[PIXEL_BITS-1:0];
        REG_SCENE:      scene_tag       <= cfg_data[SCENE_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign items.ready = (st == S_IDLE);
  assign accept      = items.valid && items.ready;
  assign report_ok   = (items.reported_scene == scene_tag)
                    && (items.line_number < INDEX_BITS'(lines_n))
                    && (items.reported_pixels == pixels_per_line)
                    && !image_done;
  assign scan_issue  = (st == S_SCAN) && (scan_ptr < lines_n);
  assign out_free    = !out_valid || results.ready;

  always_comb begin
    case (st)
      S_IDLE:  rd_addr = (items.opcode == OP_REQUEST) ? given_count[LINE_BITS-1:0]
                                                      : items.line_number[LINE_BITS-1:0];
      S_SCAN:  rd_addr = scan_ptr[LINE_BITS-1:0];
      default: rd_addr = '0;
    endcase
  end

  // A grant keeps the line's received mark; a report keeps the line's stamp.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur_line;
    mem_wdata = '0;
    case (st)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = scan_ptr[LINE_BITS-1:0];
      end
      S_GRANT_RD: begin
        mem_we             = 1'b1;
        mem_wdata.received = rdata.received;
        mem_wdata.stamp    = now_r;
      end
      S_REP_RD: begin
        mem_we             = !rdata.received;
        mem_wdata.received = 1'b1;
        mem_wdata.stamp    = rdata.stamp;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st          <= S_CLEAR;
      clr_answer  <= 1'b0;
      given_count <= '0;
      recv_count  <= '0;
      image_done  <= 1'b0;
      scan_ptr    <= '0;
      rd_v        <= 1'b0;
    end else begin
      case (st)
        S_CLEAR: begin
          scan_ptr <= scan_ptr + 1'b1;
          if (scan_ptr == CNT_BITS'(LINE_MAX - 1)) begin
            st <= clr_answer ? S_DIV_GO : S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            case (items.opcode)
              OP_REQUEST: begin
                if (image_done) begin
                  st <= S_DIV_GO;
                end else if (given_count < lines_n) begin
                  st <= S_GRANT_RD;
                end else begin
                  scan_ptr <= '0;
                  rd_v     <= 1'b0;
                  st       <= S_SCAN;
                end
              end
              OP_REPORT: begin
                st <= report_ok ? S_REP_RD : S_DIV_GO;
              end
              OP_RESTART: begin
                given_count <= '0;
                recv_count  <= '0;
                image_done  <= 1'b0;
                clr_answer  <= 1'b1;
                scan_ptr    <= '0;
                st          <= S_CLEAR;
              end
              default: st <= S_DIV_GO;
            endcase
          end
        end
        S_GRANT_RD: begin
          given_count <= given_count + 1'b1;
          st          <= S_DIV_GO;
        end
        S_REP_RD: begin
          if (rdata.received) begin
            st <= S_DIV_GO;
          end else begin
            recv_count <= recv_count + 1'b1;
            scan_ptr   <= '0;
            rd_v       <= 1'b0;
            st         <= S_SCAN;
          end
        end
        S_SCAN: begin
          rd_v <= scan_issue;
          if (scan_issue) begin
            scan_ptr <= scan_ptr + 1'b1;
          end
          if (!scan_issue && !rd_v) begin
            if (!found) begin
              image_done <= 1'b1;
            end
            st <= S_DIV_GO;
          end
        end
        S_DIV_GO: st <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (div_rsp.done) begin
            st <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            st <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  // Item payload and the scan's running choice.
  always_ff @(posedge clk) begin
    rd_idx <= scan_ptr[LINE_BITS-1:0];
    case (st)
      S_IDLE: begin
        found      <= 1'b0;
        best       <= '0;
        best_stamp <= '0;
        res_line   <= '0;
        now_r      <= items.now_time;
        if (items.opcode == OP_REQUEST) begin
          cur_line <= given_count[LINE_BITS-1:0];
        end else begin
          cur_line <= items.line_number[LINE_BITS-1:0];
        end
        scan_report <= (items.opcode == OP_REPORT);
        case (items.opcode)
          OP_REQUEST: res_status <= ST_NONE;
          OP_REPORT:  res_status <= ST_REJECT;
          OP_RESTART: res_status <= ST_NONE;
          default:    res_status <= ST_REJECT;
        endcase
      end
      S_GRANT_RD: begin
        res_status <= ST_GRANTED;
        res_line   <= cur_line;
      end
      S_REP_RD: begin
        res_status <= ST_DUP;
      end
      S_SCAN: begin
        // Strict compare: on equal stamps the lower index stays.
        if (rd_v && !rdata.received && (!found || rdata.stamp < best_stamp)) begin
          found      <= 1'b1;
          best       <= rd_idx;
          best_stamp <= rdata.stamp;
        end
        if (!scan_issue && !rd_v) begin
          if (scan_report) begin
            res_status <= found ? ST_STORED : ST_COMPLETE;
          end else if (found) begin
            res_status <= ST_GRANTED;
            res_line   <= best;
          end else begin
            res_status <= ST_NONE;
          end
        end
      end
      default: ;
    endcase
  end

  assign div_req.start    = (st == S_DIV_GO);
  assign div_req.dividend = DIVIDEND_BITS'(recv_count) * DIVIDEND_BITS'(PCT_SCALE);
  assign div_req.divisor  = lines_n;

  wld_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Latched quotient holds after the divider's last step.
  assign pct = (div_rsp.quotient > DIVIDEND_BITS'(PCT_SCALE)) ? PCT_BITS'(PCT_SCALE)
                                                               : div_rsp.quotient[PCT_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (st == S_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st == S_FIN && out_free) begin
      out_status <= res_status;
      out_line   <= res_line;
      out_pct    <= pct;
    end
  end

  assign results.valid        = out_valid;
  assign results.status       = out_status;
  assign results.granted_line = out_line;
  assign results.percent_done = out_pct;

  // A stored report counts exactly one more received line.
  a_recv_count: assert property (@(posedge clk) disable iff (rst)
    (st == S_REP_RD && !rdata.received) |=> recv_count == CNT_BITS'($past(recv_count) + 1'b1))
    else $error("received count did not advance on a stored report");

  // A waiting result is never overwritten by the next item's result.
  a_hold_fin: assert property (@(posedge clk) disable iff (rst)
    (st == S_FIN && out_valid && !results.ready) |=> st == S_FIN)
    else $error("result register overwritten while the receiver stalls");

  // The image is marked done only at the end of a table scan.
  a_done_scan: assert property (@(posedge clk) disable iff (rst)
    $rose(image_done) |-> $past(st) == S_SCAN)
    else $error("image marked done outside a scan");

  // The divider answers only while the sequencer waits for it.
  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> st == S_DIV_WAIT)
    else $error("divider finished outside the wait state");

endmodule

### tb/work_line_dispatcher_tb.sv
// Self-checking testbench for work_line_dispatcher: directed table, then random phases.
module work_line_dispatcher_tb;
  import wld_pkg::*;

  // Clock, reset and run-length settings. The watchdog limit is far above the
  // slowest item: a full-table walk at 1024 lines plus a clearing pass plus the
  // longest hold-off on the result side.
  localparam int CLK_HIGH      = 5;
  localparam int CLK_LOW       = 5;
  localparam int RESET_CYCLES  = 12;
  localparam int QUIET_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int HOLD_AT_BEAT  = 260;
  localparam int CALM_FIRST    = 250;
  localparam int CALM_LAST     = 350;
  localparam int INDEX_TOP     = (1 << INDEX_BITS) - 1;

  // Codes the package does not name: the fourth opcode and the unused register slot.
  localparam logic [OP_BITS-1:0]        OP_UNKNOWN = 2'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE  = 2'd3;

  // Random phases: line total (0 and 2047 exercise the clamp), pixels per line,
  // scene tag (zero means pick one at random) and number of beats.
  localparam int PHASES = 6;
  localparam int PHASE_LINES  [PHASES] = '{4, 2047, 0, 8, 16, 3};
  localparam int PHASE_PIXELS [PHASES] = '{640, 65535, 1, 1920, 37, 480};
  localparam int PHASE_SCENE  [PHASES] = '{0, 32'h7FFF_FFFF, 1, 0, 0, 0};
  localparam int PHASE_BEATS  [PHASES] = '{110, 20, 60, 150, 110, 90};

  typedef struct packed {
    logic [OP_BITS-1:0]    opcode;
    logic [INDEX_BITS-1:0] line_number;
    logic [SCENE_BITS-1:0] reported_scene;
    logic [PIXEL_BITS-1:0] reported_pixels;
    logic [TIME_BITS-1:0]  now_time;
  } work_item_t;

  typedef struct packed {
    logic [STATUS_BITS-1:0] status;
    logic [LINE_BITS-1:0]   granted_line;
    logic [PCT_BITS-1:0]    percent_done;
  } line_result_t;

  typedef enum logic {ROW_BEAT, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t                 kind;
    work_item_t                beat;
    bit                        by_hand;
    line_result_t              answer;
    logic [CFG_INDEX_BITS-1:0] reg_index;
    logic [CFG_DATA_BITS-1:0]  reg_data;
  } script_row_t;

  logic                      clk;
  logic                      rst;
  logic                      cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  wld_item_if   items ();
  wld_result_if results ();

  work_line_dispatcher uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .items     (items),
    .results   (results)
  );

  // Shadow copy of the dispatcher: registers and the line table.
  logic [CNT_BITS-1:0]   lines_reg;
  logic [PIXEL_BITS-1:0] pixels_reg;
  logic [SCENE_BITS-1:0] scene_reg;
  bit                    line_given [LINE_MAX];
  bit                    line_rcvd  [LINE_MAX];
  logic [STAMP_BITS-1:0] line_stamp [LINE_MAX];
  int unsigned           rcvd_total;
  bit                    image_closed;

  // Results the block still owes, oldest first.
  line_result_t owed_results [$];
  script_row_t  script_rows [$];

  bit calm;
  int errors;
  int beats_sent;
  int results_seen;
  int regs_written;
  int images_done;
  int restarts;
  int quiet_cycles;

  initial clk = 1'b0;
  always begin
    #CLK_HIGH clk = 1'b1;
    #CLK_LOW  clk = 1'b0;
  end

  // The line total register is clamped into 1..LINE_MAX before use.
  function automatic int lines_in_play();
    int n;
    n = int'(lines_reg);
    if (n < 1) n = 1;
    if (n > LINE_MAX) n = LINE_MAX;
    return n;
  endfunction

  function automatic logic [PCT_BITS-1:0] percent_now();
    int unsigned p;
    p = (rcvd_total * PCT_SCALE) / lines_in_play();
    if (p > PCT_SCALE) p = PCT_SCALE;
    return PCT_BITS'(p);
  endfunction

  function automatic void clear_table();
    for (int i = 0; i < LINE_MAX; i++) begin
      line_given[i] = 1'b0;
      line_rcvd[i]  = 1'b0;
      line_stamp[i] = '0;
    end
    rcvd_total   = 0;
    image_closed = 1'b0;
  endfunction

  // Applies one beat to the shadow table and returns the answer it must produce.
  function automatic line_result_t predict_dispatch(work_item_t b);
    line_result_t          r;
    int                    n;
    int                    pick;
    logic [STAMP_BITS-1:0] oldest;
    n      = lines_in_play();
    pick   = -1;
    oldest = '0;
    r.status       = ST_REJECT;
    r.granted_line = '0;
    case (b.opcode)
      OP_REQUEST: begin
        if (image_closed) begin
          r.status = ST_NONE;
        end else begin
          // A line that was never handed out wins; it takes the current time.
          for (int i = 0; i < n; i++)
            if (pick < 0 && !line_given[i]) pick = i;
          if (pick >= 0) begin
            line_given[pick] = 1'b1;
            line_stamp[pick] = b.now_time;
          end else begin
            // Otherwise the unreceived line with the oldest stamp, lowest index on a
            // tie; its stamp is left as it was.
            for (int i = 0; i < n; i++)
              if (!line_rcvd[i] && (pick < 0 || line_stamp[i] < oldest)) begin
                pick   = i;
                oldest = line_stamp[i];
              end
          end
          if (pick >= 0) begin
            r.status       = ST_GRANTED;
            r.granted_line = LINE_BITS'(pick);
          end else begin
            image_closed = 1'b1;
            r.status     = ST_NONE;
          end
        end
      end
      OP_REPORT: begin
        if (b.reported_scene != scene_reg || int'(b.line_number) >= n ||
            b.reported_pixels != pixels_reg || image_closed) begin
          r.status = ST_REJECT;
        end else if (line_rcvd[b.line_number]) begin
          r.status = ST_DUP;
        end else begin
          line_rcvd[b.line_number] = 1'b1;
          rcvd_total++;
          r.status = ST_COMPLETE;
          for (int i = 0; i < n; i++)
            if (!line_rcvd[i]) r.status = ST_STORED;
          if (r.status == ST_COMPLETE) image_closed = 1'b1;
        end
      end
      OP_RESTART: begin
        clear_table();
        r.status = ST_NONE;
      end
      default: r.status = ST_REJECT;
    endcase
    r.percent_done = percent_now();
    return r;
  endfunction

  // Random beat shaped by the shadow table: mostly requests and well-formed reports
  // of lines that are out with a worker, with some malformed reports and restarts.
  // Once the image is complete, restarts become common so that new images begin.
  function automatic work_item_t random_beat();
    work_item_t b;
    int         n;
    int         roll;
    int         open_lines [$];
    int         done_lines [$];
    n = lines_in_play();
    b.opcode          = OP_REQUEST;
    b.line_number     = INDEX_BITS'($urandom);
    b.reported_scene  = SCENE_BITS'($urandom);
    b.reported_pixels = PIXEL_BITS'($urandom);
    // Small stamps make ties, the extremes check the stamp compare at its ends.
    case ($urandom_range(0, 3))
      0:       b.now_time = TIME_BITS'($urandom_range(0, 15));
      1:       b.now_time = $urandom_range(0, 1) ? '1 : '0;
      default: b.now_time = TIME_BITS'($urandom);
    endcase
    for (int i = 0; i < n; i++) begin
      if (line_given[i] && !line_rcvd[i]) open_lines.push_back(i);
      if (line_rcvd[i]) done_lines.push_back(i);
    end
    roll = $urandom_range(0, 99);
    if (roll < (image_closed ? 35 : 2)) begin
      b.opcode = OP_RESTART;
    end else if (roll < 45) begin
      b.opcode = OP_REQUEST;
    end else begin
      b.opcode          = OP_REPORT;
      b.reported_scene  = scene_reg;
      b.reported_pixels = pixels_reg;
      b.line_number     = INDEX_BITS'($urandom_range(0, n - 1));
      if (roll < 85) begin
        if (open_lines.size() != 0 && $urandom_range(0, 4) != 0)
          b.line_number = INDEX_BITS'(open_lines[$urandom_range(0, open_lines.size() - 1)]);
      end else begin
        case ($urandom_range(0, 4))
          0: b.reported_scene = scene_reg ^ (SCENE_BITS'(1) << $urandom_range(0, SCENE_BITS - 1));
          1: b.reported_pixels = pixels_reg ^ (PIXEL_BITS'(1) << $urandom_range(0, PIXEL_BITS - 1));
          2: b.line_number = INDEX_BITS'($urandom_range(n, INDEX_TOP));
          3: begin
            b.opcode          = OP_UNKNOWN;
            b.line_number     = INDEX_BITS'($urandom);
            b.reported_scene  = SCENE_BITS'($urandom);
            b.reported_pixels = PIXEL_BITS'($urandom);
          end
          default: begin
            if (done_lines.size() != 0)
              b.line_number = INDEX_BITS'(done_lines[$urandom_range(0, done_lines.size() - 1)]);
          end
        endcase
      end
    end
    return b;
  endfunction

  function automatic void row_beat(logic [OP_BITS-1:0] op, logic [INDEX_BITS-1:0] line,
                                   logic [SCENE_BITS-1:0] scene, logic [PIXEL_BITS-1:0] pix,
                                   logic [TIME_BITS-1:0] now, bit by_hand,
                                   logic [STATUS_BITS-1:0] st, logic [LINE_BITS-1:0] gl,
                                   logic [PCT_BITS-1:0] pct);
    script_row_t row;
    row.kind      = ROW_BEAT;
    row.beat      = '{op, line, scene, pix, now};
    row.by_hand   = by_hand;
    row.answer    = '{st, gl, pct};
    row.reg_index = REG_SPARE;
    row.reg_data  = '0;
    script_rows.push_back(row);
  endfunction

  function automatic void row_reg(logic [CFG_INDEX_BITS-1:0] idx,
                                  logic [CFG_DATA_BITS-1:0] data);
    script_row_t row;
    row.kind      = ROW_REG;
    row.beat      = '0;
    row.by_hand   = 1'b0;
    row.answer    = '0;
    row.reg_index = idx;
    row.reg_data  = data;
    script_rows.push_back(row);
  endfunction

  // One register write: the enable is high for exactly one edge. The leading wait
  // keeps back-to-back writes from lowering and raising the enable in one step.
  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_LINE_TOTAL: lines_reg  = data[CNT_BITS-1:0];
      REG_PIXELS:     pixels_reg = data[PIXEL_BITS-1:0];
      REG_SCENE:      scene_reg  = data[SCENE_BITS-1:0];
      default:        ;
    endcase
    regs_written++;
  endtask

  // Stops offering beats and waits until every owed result has come back, then a
  // little longer so that the block is idle before the registers change.
  task automatic drain();
    items.valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Offers one beat, possibly after a random gap, and holds it until the block
  // takes it. The expected answer is worked out at the edge of acceptance. If
  // there is no gap, valid simply stays high from the previous beat.
  task automatic send_beat(work_item_t b, bit by_hand, line_result_t answer);
    line_result_t r;
    int           gap;
    gap = 0;
    if (!calm && $urandom_range(0, 99) < 30)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 8);
    if (gap > 0) begin
      items.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    items.valid           <= 1'b1;
    items.opcode          <= b.opcode;
    items.line_number     <= b.line_number;
    items.reported_scene  <= b.reported_scene;
    items.reported_pixels <= b.reported_pixels;
    items.now_time        <= b.now_time;
    @(posedge clk);
    while (!items.ready) @(posedge clk);
    r = predict_dispatch(b);
    owed_results.push_back(by_hand ? answer : r);
    beats_sent++;
    if (r.status == ST_COMPLETE) images_done++;
    if (b.opcode == OP_RESTART) restarts++;
  endtask

  // Result side: checks every accepted beat against the oldest owed result and
  // throttles ready. Once, after enough results, it refuses beats for a long
  // stretch so that the result register and then the input side back up.
  initial begin : result_sink
    line_result_t want;
    int           hold_left;
    bit           hold_used;
    hold_left = 0;
    hold_used = 1'b0;
    results.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (results.valid && results.ready) begin
        results_seen++;
        if (owed_results.size() == 0) begin
          $error("result beat with nothing owed: status %0d line %0d percent %0d",
                 results.status, results.granted_line, results.percent_done);
          errors++;
        end else begin
          want = owed_results.pop_front();
          if (results.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, results.status);
            errors++;
          end
          if (results.granted_line !== want.granted_line) begin
            $error("granted_line: expected %0d, got %0d", want.granted_line,
                   results.granted_line);
            errors++;
          end
          if (results.percent_done !== want.percent_done) begin
            $error("percent_done: expected %0d, got %0d", want.percent_done,
                   results.percent_done);
            errors++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        results.ready <= 1'b0;
      end else if (!hold_used && results_seen >= HOLD_AT_BEAT) begin
        hold_used = 1'b1;
        hold_left = HOLD_CYCLES;
        results.ready <= 1'b0;
      end else begin
        results.ready <= calm || ($urandom_range(0, 99) >= 30);
      end
    end
  end

  // Watchdog: counts edges at which no beat moves on either channel.
  always @(posedge clk) begin
    if ((items.valid && items.ready) || (results.valid && results.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $error("no beat moved for %0d cycles", QUIET_LIMIT);
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int rand_idx;
    rand_idx = 0;
    errors       = 0;
    beats_sent   = 0;
    results_seen = 0;
    regs_written = 0;
    images_done  = 0;
    restarts     = 0;
    quiet_cycles = 0;
    calm         = 1'b0;

    rst                   <= 1'b1;
    cfg_we                <= 1'b0;
    cfg_index             <= REG_LINE_TOTAL;
    cfg_data              <= '0;
    items.valid           <= 1'b0;
    items.opcode          <= OP_REQUEST;
    items.line_number     <= '0;
    items.reported_scene  <= '0;
    items.reported_pixels <= '0;
    items.now_time        <= '0;

    // Register values after reset: one line, one pixel, scene one.
    lines_reg  = CNT_BITS'(1);
    pixels_reg = PIXEL_BITS'(1);
    scene_reg  = SCENE_BITS'(1);
    clear_table();

    // Directed table. With the reset settings there is a single line: it is
    // granted, re-granted with its stamp kept, refused on every malformed report,
    // finished, and then the finished image refuses reports and requests.
    row_beat(OP_REQUEST, 0, 1, 1, '1, 1, ST_GRANTED, 0, 0);
    row_beat(OP_REQUEST, '1, '1, '1, '0, 1, ST_GRANTED, 0, 0);
    row_beat(OP_REPORT, 0, '1, 1, 0, 1, ST_REJECT, 0, 0);
    row_beat(OP_REPORT, '1, 1, 1, 0, 1, ST_REJECT, 0, 0);
    row_beat(OP_REPORT, 0, 1, '1, 0, 1, ST_REJECT, 0, 0);
    row_beat(OP_REPORT, 0, 1, 0, 0, 1, ST_REJECT, 0, 0);
    row_beat(OP_UNKNOWN, '1, '1, '1, '1, 1, ST_REJECT, 0, 0);
    row_beat(OP_REPORT, 0, 1, 1, 0, 1, ST_COMPLETE, 0, 100);
    row_beat(OP_REPORT, 0, 1, 1, 0, 1, ST_REJECT, 0, 100);
    row_beat(OP_REQUEST, 0, 1, 1, 7, 1, ST_NONE, 0, 100);
    row_beat(OP_RESTART, 0, 1, 1, 0, 1, ST_NONE, 0, 0);
    // Two lines at the widest pixel count and scene: a report of a line that was
    // never granted is stored, its repeat is a duplicate, index two is refused.
    row_reg(REG_LINE_TOTAL, 2);
    row_reg(REG_PIXELS, 16'hFFFF);
    row_reg(REG_SCENE, 31'h7FFF_FFFF);
    row_beat(OP_REPORT, 0, '1, '1, 0, 1, ST_STORED, 0, 50);
    row_beat(OP_REPORT, 0, '1, '1, 0, 1, ST_DUP, 0, 50);
    row_beat(OP_REPORT, 2, '1, '1, 0, 1, ST_REJECT, 0, 50);
    // Shrinking to one line leaves a table where every line is received but none
    // is given: one grant, then a request finds nothing left and closes the image.
    row_reg(REG_LINE_TOTAL, 1);
    row_beat(OP_REQUEST, 0, 0, 0, 3, 1, ST_GRANTED, 0, 100);
    row_beat(OP_REQUEST, 0, 0, 0, 4, 1, ST_NONE, 0, 100);
    row_beat(OP_REPORT, 0, '1, '1, 0, 1, ST_REJECT, 0, 100);
    row_beat(OP_RESTART, 0, 0, 0, 0, 1, ST_NONE, 0, 0);
    // Three lines: stamps 50, 10, 10 make a tie on the oldest stamp, which goes to
    // the lower index; the later rows are checked against the shadow table.
    row_reg(REG_LINE_TOTAL, 3);
    row_beat(OP_REQUEST, 0, 0, 0, 50, 1, ST_GRANTED, 0, 0);
    row_beat(OP_REQUEST, 0, 0, 0, 10, 1, ST_GRANTED, 1, 0);
    row_beat(OP_REQUEST, 0, 0, 0, 10, 1, ST_GRANTED, 2, 0);
    row_beat(OP_REQUEST, 0, 0, 0, 99, 1, ST_GRANTED, 1, 0);
    row_beat(OP_REPORT, 1, '1, '1, 0, 0, ST_REJECT, 0, 0);
    row_beat(OP_REQUEST, 0, 0, 0, 0, 0, ST_REJECT, 0, 0);
    row_beat(OP_REQUEST, 0, 0, 0, 1, 0, ST_REJECT, 0, 0);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // The block runs its clearing pass after reset; the first beat simply waits
    // for ready. Register rows are only written once the block has drained.
    foreach (script_rows[i]) begin
      if (script_rows[i].kind == ROW_REG) begin
        drain();
        write_reg(script_rows[i].reg_index, script_rows[i].reg_data);
      end else begin
        send_beat(script_rows[i].beat, script_rows[i].by_hand, script_rows[i].answer);
      end
    end

    // Random phases. The line table carries over from one phase to the next, as it
    // does in the block; only restarts clear it. The widest phase is kept short
    // because stored reports and re-grants walk the whole table there.
    for (int p = 0; p < PHASES; p++) begin
      drain();
      write_reg(REG_LINE_TOTAL, CFG_DATA_BITS'(PHASE_LINES[p]));
      write_reg(REG_PIXELS, CFG_DATA_BITS'(PHASE_PIXELS[p]));
      write_reg(REG_SCENE, (PHASE_SCENE[p] == 0) ?
                CFG_DATA_BITS'($urandom_range(1, 32'h7FFF_FFFF)) :
                CFG_DATA_BITS'(PHASE_SCENE[p]));
      write_reg(REG_SPARE, CFG_DATA_BITS'($urandom));
      for (int k = 0; k < PHASE_BEATS[p]; k++) begin
        // A stretch in the middle of the run with no idling on either side.
        calm = (rand_idx >= CALM_FIRST && rand_idx < CALM_LAST);
        send_beat(random_beat(), 1'b0, '0);
        rand_idx++;
      end
    end
    calm = 1'b0;

    // All beats are in: wait for the last results, then a settling margin. The
    // watchdog bounds this wait.
    drain();

    $display("Summary: %0d beats sent (%0d from the table), %0d results checked, %0d register writes.",
             beats_sent, beats_sent - rand_idx, results_seen, regs_written);
    $display("Summary: %0d images finished, %0d restarts, %0d random phases up to %0d lines.",
             images_done, restarts, PHASES, LINE_MAX);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
